[rtl/pch_pkg.sv]
// shared types, constants and helper functions of the particle cell histogram
package pch_pkg;

  localparam int FINE_NX   = 20;
  localparam int FINE_NY   = 20;
  localparam int FINE_NZ   = 6;
  localparam int COARSE_NX = 16;
  localparam int COARSE_NY = 16;
  localparam int COARSE_NZ = 5;

  localparam int FINE_CELLS   = FINE_NX * FINE_NY * FINE_NZ;
  localparam int COARSE_CELLS = COARSE_NX * COARSE_NY * COARSE_NZ;
  localparam int MAX_CELLS    = (FINE_CELLS > COARSE_CELLS) ? FINE_CELLS : COARSE_CELLS;

  localparam int FINE_AW   = (FINE_CELLS > 1) ? $clog2(FINE_CELLS) : 1;
  localparam int COARSE_AW = (COARSE_CELLS > 1) ? $clog2(COARSE_CELLS) : 1;
  localparam int CLR_W     = $clog2(MAX_CELLS) + 1;
  localparam int ADDR_W    = 18;

  localparam int POS_W       = 26;
  localparam int D_W         = POS_W + 1;
  localparam int CPM_W       = 16;
  localparam int RAD_W       = 21;
  localparam int IDX_W       = 6;
  localparam int COUNT_W     = 16;
  localparam int SCALE_SHIFT = 28;
  localparam int PROD_W      = (D_W - 1) + CPM_W;
  localparam int Q_W         = PROD_W - SCALE_SHIFT;

  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DMIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DMIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DMIN_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FINE_CPM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_CPM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAD_THR    = 3'd5;

  localparam logic signed [POS_W-1:0] DMIN_X_RST     = -26'sd104858;
  localparam logic signed [POS_W-1:0] DMIN_Y_RST     = -26'sd104858;
  localparam logic signed [POS_W-1:0] DMIN_Z_RST     = -26'sd31457;
  localparam logic [CPM_W-1:0]        FINE_CPM_RST   = 16'd25600;
  localparam logic [CPM_W-1:0]        COARSE_CPM_RST = 16'd20480;
  localparam logic [RAD_W-1:0]        RAD_THR_RST    = 21'd0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int LOAD_W      = QCNT_W + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic signed [POS_W-1:0] dmin_x;
    logic signed [POS_W-1:0] dmin_y;
    logic signed [POS_W-1:0] dmin_z;
    logic [CPM_W-1:0]        fine_cpm;
    logic [CPM_W-1:0]        coarse_cpm;
    logic [RAD_W-1:0]        rad_thr;
  } cfg_t;

  typedef struct packed {
    op_e                  op;
    logic [IDX_W-1:0]     fx;
    logic [IDX_W-1:0]     fy;
    logic [IDX_W-1:0]     fz;
    logic [IDX_W-1:0]     cx;
    logic [IDX_W-1:0]     cy;
    logic [IDX_W-1:0]     cz;
    logic                 is_large;
    logic                 grid;
    logic                 rd_ok;
    logic [FINE_AW-1:0]   faddr;
    logic [COARSE_AW-1:0] caddr;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]   fx;
    logic [IDX_W-1:0]   fy;
    logic [IDX_W-1:0]   fz;
    logic [IDX_W-1:0]   cx;
    logic [IDX_W-1:0]   cy;
    logic [IDX_W-1:0]   cz;
    logic               is_large;
    logic [COUNT_W-1:0] cnt_l;
    logic [COUNT_W-1:0] cnt_s;
  } res_t;

  function automatic logic [IDX_W-1:0] clamp_idx(logic [Q_W-1:0] q, int n);
    logic [Q_W-1:0] lim;
    lim = Q_W'(n - 1);
    return (q > lim) ? lim[IDX_W-1:0] : q[IDX_W-1:0];
  endfunction

  function automatic logic in_range(logic [IDX_W-1:0] v, int n);
    return {1'b0, v} < (IDX_W + 1)'(n);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y,
                                                  logic [IDX_W-1:0] z, int nx, int ny);
    return ADDR_W'(x) + ADDR_W'(nx) * (ADDR_W'(y) + ADDR_W'(ny) * ADDR_W'(z));
  endfunction

endpackage

[rtl/pch_ram.sv]
// generic single port write, single port read ram with registered read data
module pch_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/pch_front.sv]
// front end: offsets, scaling multiplies, clamping and cell addresses of each item
module pch_front
  import pch_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [1:0]              operation_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic [RAD_W-1:0]        radius_i,
  input  logic                    grid_select_i,
  input  logic [IDX_W-1:0]        read_x_i,
  input  logic [IDX_W-1:0]        read_y_i,
  input  logic [IDX_W-1:0]        read_z_i,
  input  cfg_t                    cfg_i,
  output logic                    push_o,
  output entry_t                  entry_o,
  output logic [1:0]              inflight_o
);

  logic                    s1_v_q;
  op_e                     s1_op_q;
  logic signed [D_W-1:0]   s1_d_q [3];
  logic                    s1_large_q;
  logic                    s1_grid_q;
  logic [IDX_W-1:0]        s1_rd_q [3];

  logic                    s2_v_q;
  op_e                     s2_op_q;
  logic [Q_W-1:0]          s2_qf_q [3];
  logic [Q_W-1:0]          s2_qc_q [3];
  logic                    s2_large_q;
  logic                    s2_grid_q;
  logic [IDX_W-1:0]        s2_rd_q [3];

  logic signed [POS_W-1:0] pos [3];
  logic signed [POS_W-1:0] dmin [3];
  logic signed [D_W-1:0]   d_d [3];
  logic [PROD_W-1:0]       pf [3];
  logic [PROD_W-1:0]       pc [3];

  assign pos  = '{pos_x_i, pos_y_i, pos_z_i};
  assign dmin = '{cfg_i.dmin_x, cfg_i.dmin_y, cfg_i.dmin_z};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_d[a] = $signed({pos[a][POS_W-1], pos[a]}) - $signed({dmin[a][POS_W-1], dmin[a]});
      if (s1_d_q[a][D_W-1] || (s1_d_q[a] == '0)) begin
        pf[a] = '0;
        pc[a] = '0;
      end else begin
        pf[a] = PROD_W'(s1_d_q[a][D_W-2:0]) * PROD_W'(cfg_i.fine_cpm);
        pc[a] = PROD_W'(s1_d_q[a][D_W-2:0]) * PROD_W'(cfg_i.coarse_cpm);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept_i;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_op_q    <= op_e'(operation_i);
      s1_d_q     <= d_d;
      s1_large_q <= radius_i > cfg_i.rad_thr;
      s1_grid_q  <= grid_select_i;
      s1_rd_q    <= '{read_x_i, read_y_i, read_z_i};
    end
    if (s1_v_q) begin
      s2_op_q    <= s1_op_q;
      s2_large_q <= s1_large_q;
      s2_grid_q  <= s1_grid_q;
      s2_rd_q    <= s1_rd_q;
      for (int a = 0; a < 3; a++) begin
        s2_qf_q[a] <= pf[a][PROD_W-1:SCALE_SHIFT];
        s2_qc_q[a] <= pc[a][PROD_W-1:SCALE_SHIFT];
      end
    end
  end

  logic [IDX_W-1:0]  fx, fy, fz, cx, cy, cz;
  logic [ADDR_W-1:0] fa_add, ca_add, fa_rd, ca_rd;
  logic              rd_ok;

  always_comb begin
    fx = clamp_idx(s2_qf_q[0], FINE_NX);
    fy = clamp_idx(s2_qf_q[1], FINE_NY);
    fz = clamp_idx(s2_qf_q[2], FINE_NZ);
    cx = clamp_idx(s2_qc_q[0], COARSE_NX);
    cy = clamp_idx(s2_qc_q[1], COARSE_NY);
    cz = clamp_idx(s2_qc_q[2], COARSE_NZ);
    fa_add = cell_addr(fx, fy, fz, FINE_NX, FINE_NY);
    ca_add = cell_addr(cx, cy, cz, COARSE_NX, COARSE_NY);
    fa_rd  = cell_addr(s2_rd_q[0], s2_rd_q[1], s2_rd_q[2], FINE_NX, FINE_NY);
    ca_rd  = cell_addr(s2_rd_q[0], s2_rd_q[1], s2_rd_q[2], COARSE_NX, COARSE_NY);
    if (s2_grid_q) begin
      rd_ok = in_range(s2_rd_q[0], COARSE_NX) && in_range(s2_rd_q[1], COARSE_NY) &&
              in_range(s2_rd_q[2], COARSE_NZ);
    end else begin
      rd_ok = in_range(s2_rd_q[0], FINE_NX) && in_range(s2_rd_q[1], FINE_NY) &&
              in_range(s2_rd_q[2], FINE_NZ);
    end

    entry_o.op       = s2_op_q;
    entry_o.fx       = fx;
    entry_o.fy       = fy;
    entry_o.fz       = fz;
    entry_o.cx       = cx;
    entry_o.cy       = cy;
    entry_o.cz       = cz;
    entry_o.is_large = s2_large_q;
    entry_o.grid     = s2_grid_q;
    entry_o.rd_ok    = rd_ok;
    if (s2_op_q == OP_READ) begin
      entry_o.faddr = fa_rd[FINE_AW-1:0];
      entry_o.caddr = ca_rd[COARSE_AW-1:0];
    end else begin
      entry_o.faddr = fa_add[FINE_AW-1:0];
      entry_o.caddr = ca_add[COARSE_AW-1:0];
    end
  end

  assign push_o     = s2_v_q;
  assign inflight_o = {1'b0, s1_v_q} + {1'b0, s2_v_q};

endmodule

[rtl/pch_queue.sv]
// short item queue between front end and counter back end
module pch_queue
  import pch_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  entry_t            entry_i,
  input  logic              pop_i,
  output logic              valid_o,
  output entry_t            head_o,
  output logic [QCNT_W-1:0] count_o
);

  entry_t            mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/pch_back.sv]
// back end: counter memories, read-modify-write, clear sweep and result register
module pch_back
  import pch_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   q_valid_i,
  input  entry_t head_i,
  output logic   pop_o,
  output logic   init_o,
  output logic   res_valid_o,
  output res_t   res_o
);

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } state_e;

  state_e           state_q;
  logic [CLR_W-1:0] clr_q;
  logic             report_q;
  entry_t           cur_q;
  logic             res_valid_q;
  res_t             res_q;

  logic                 fl_we, fs_we, cl_we, cs_we;
  logic [FINE_AW-1:0]   f_waddr;
  logic [COARSE_AW-1:0] c_waddr;
  logic [COUNT_W-1:0]   fl_wdata, fs_wdata, cl_wdata, cs_wdata;
  logic [COUNT_W-1:0]   fl_rdata, fs_rdata, cl_rdata, cs_rdata;
  logic                 clr_last;
  res_t                 exec_res;

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign pop_o    = (state_q == BK_IDLE) && q_valid_i;
  assign init_o   = (state_q == BK_CLEAR) && !report_q;
  assign clr_last = clr_q == CLR_W'(MAX_CELLS - 1);

  always_comb begin
    fl_we    = 1'b0;
    fs_we    = 1'b0;
    cl_we    = 1'b0;
    cs_we    = 1'b0;
    f_waddr  = cur_q.faddr;
    c_waddr  = cur_q.caddr;
    fl_wdata = sat_inc(fl_rdata);
    fs_wdata = sat_inc(fs_rdata);
    cl_wdata = sat_inc(cl_rdata);
    cs_wdata = sat_inc(cs_rdata);
    case (state_q)
      BK_CLEAR: begin
        f_waddr  = clr_q[FINE_AW-1:0];
        c_waddr  = clr_q[COARSE_AW-1:0];
        fl_wdata = '0;
        fs_wdata = '0;
        cl_wdata = '0;
        cs_wdata = '0;
        fl_we    = clr_q < CLR_W'(FINE_CELLS);
        fs_we    = fl_we;
        cl_we    = clr_q < CLR_W'(COARSE_CELLS);
        cs_we    = cl_we;
      end
      BK_EXEC: begin
        fl_we = (cur_q.op == OP_ADD) && cur_q.is_large;
        fs_we = (cur_q.op == OP_ADD) && !cur_q.is_large;
        cl_we = fl_we;
        cs_we = fs_we;
      end
      default: ;
    endcase
  end

  always_comb begin
    exec_res = '0;
    case (cur_q.op)
      OP_ADD: begin
        exec_res.fx       = cur_q.fx;
        exec_res.fy       = cur_q.fy;
        exec_res.fz       = cur_q.fz;
        exec_res.cx       = cur_q.cx;
        exec_res.cy       = cur_q.cy;
        exec_res.cz       = cur_q.cz;
        exec_res.is_large = cur_q.is_large;
      end
      OP_READ: begin
        if (cur_q.rd_ok) begin
          exec_res.cnt_l = cur_q.grid ? cl_rdata : fl_rdata;
          exec_res.cnt_s = cur_q.grid ? cs_rdata : fs_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_q       <= '0;
      report_q    <= 1'b0;
      cur_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        BK_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_last) begin
            state_q <= BK_IDLE;
            if (report_q) begin
              res_valid_q <= 1'b1;
              res_q       <= '0;
            end
          end
        end
        BK_IDLE: begin
          if (q_valid_i) begin
            cur_q <= head_i;
            if (head_i.op == OP_CLEAR) begin
              state_q  <= BK_CLEAR;
              clr_q    <= '0;
              report_q <= 1'b1;
            end else begin
              state_q <= BK_EXEC;
            end
          end
        end
        BK_EXEC: begin
          state_q     <= BK_IDLE;
          res_valid_q <= 1'b1;
          res_q       <= exec_res;
        end
        default: state_q <= BK_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  pch_ram #(.WIDTH(COUNT_W), .DEPTH(FINE_CELLS)) u_fine_large (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (f_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (head_i.faddr),
    .rdata_o (fl_rdata)
  );

  pch_ram #(.WIDTH(COUNT_W), .DEPTH(FINE_CELLS)) u_fine_small (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (f_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (head_i.faddr),
    .rdata_o (fs_rdata)
  );

  pch_ram #(.WIDTH(COUNT_W), .DEPTH(COARSE_CELLS)) u_coarse_large (
    .clk_i   (clk_i),
    .we_i    (cl_we),
    .waddr_i (c_waddr),
    .wdata_i (cl_wdata),
    .raddr_i (head_i.caddr),
    .rdata_o (cl_rdata)
  );

  pch_ram #(.WIDTH(COUNT_W), .DEPTH(COARSE_CELLS)) u_coarse_small (
    .clk_i   (clk_i),
    .we_i    (cs_we),
    .waddr_i (c_waddr),
    .wdata_i (cs_wdata),
    .raddr_i (head_i.caddr),
    .rdata_o (cs_rdata)
  );

endmodule

[rtl/particle_cell_histogram_top.sv]
// top level of the particle cell histogram: config registers, front end, queue, back end
//
//   channel   handshake                  payload
//   command   start / busy               operation_i, pos_*_i, radius_i, grid_select_i, read_*_i
//   config    cfg_we_i                   cfg_index_i, cfg_data_i
//   result    result_valid_o (1 cycle)   fine_*_o, coarse_*_o, is_large_o, count_*_o
//
// the front end takes one item a cycle while the queue has room; for an add or read the
// back end reads the counter rams in its idle state and, for an add, writes them in its
// execute state, taking no new item meanwhile; a clear item sweeps all 2400 cells, one
// cell a cycle, then reports. after reset a clearing pass runs with busy high.
// with the back end idle an accepted item passes the front end registers, the queue and
// the back end idle and execute states to the result register; the receiver cannot stall.
module particle_cell_histogram_top
  import pch_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic [1:0]              operation_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic [RAD_W-1:0]        radius_i,
  input  logic                    grid_select_i,
  input  logic [IDX_W-1:0]        read_x_i,
  input  logic [IDX_W-1:0]        read_y_i,
  input  logic [IDX_W-1:0]        read_z_i,
  output logic                    result_valid_o,
  output logic [IDX_W-1:0]        fine_x_o,
  output logic [IDX_W-1:0]        fine_y_o,
  output logic [IDX_W-1:0]        fine_z_o,
  output logic [IDX_W-1:0]        coarse_x_o,
  output logic [IDX_W-1:0]        coarse_y_o,
  output logic [IDX_W-1:0]        coarse_z_o,
  output logic                    is_large_o,
  output logic [COUNT_W-1:0]      count_large_o,
  output logic [COUNT_W-1:0]      count_small_o
);

  cfg_t              cfg_q;
  logic              accept;
  logic              push;
  entry_t            push_entry;
  logic [1:0]        inflight;
  logic              pop;
  logic              q_valid;
  entry_t            head;
  logic [QCNT_W-1:0] q_cnt;
  logic              init_clear;
  logic [LOAD_W-1:0] load;
  res_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dmin_x     <= DMIN_X_RST;
      cfg_q.dmin_y     <= DMIN_Y_RST;
      cfg_q.dmin_z     <= DMIN_Z_RST;
      cfg_q.fine_cpm   <= FINE_CPM_RST;
      cfg_q.coarse_cpm <= COARSE_CPM_RST;
      cfg_q.rad_thr    <= RAD_THR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DMIN_X:     cfg_q.dmin_x     <= cfg_data_i[POS_W-1:0];
        REG_DMIN_Y:     cfg_q.dmin_y     <= cfg_data_i[POS_W-1:0];
        REG_DMIN_Z:     cfg_q.dmin_z     <= cfg_data_i[POS_W-1:0];
        REG_FINE_CPM:   cfg_q.fine_cpm   <= cfg_data_i[CPM_W-1:0];
        REG_COARSE_CPM: cfg_q.coarse_cpm <= cfg_data_i[CPM_W-1:0];
        REG_RAD_THR:    cfg_q.rad_thr    <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  assign load   = LOAD_W'(q_cnt) + LOAD_W'(inflight);
  assign busy   = init_clear || (load >= LOAD_W'(QUEUE_DEPTH));
  assign accept = start && !busy;

  pch_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .radius_i      (radius_i),
    .grid_select_i (grid_select_i),
    .read_x_i      (read_x_i),
    .read_y_i      (read_y_i),
    .read_z_i      (read_z_i),
    .cfg_i         (cfg_q),
    .push_o        (push),
    .entry_o       (push_entry),
    .inflight_o    (inflight)
  );

  pch_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head),
    .count_o (q_cnt)
  );

  pch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .init_o      (init_clear),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign fine_x_o      = res.fx;
  assign fine_y_o      = res.fy;
  assign fine_z_o      = res.fz;
  assign coarse_x_o    = res.cx;
  assign coarse_y_o    = res.cy;
  assign coarse_z_o    = res.cz;
  assign is_large_o    = res.is_large;
  assign count_large_o = res.cnt_l;
  assign count_small_o = res.cnt_s;

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load <= LOAD_W'(QUEUE_DEPTH))
    else $error("queue plus front end holds more items than the queue can take");

  a_no_result_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_clear |-> !result_valid_o)
    else $error("result while reset clearing pass runs");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("results on two cycles in a row");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (q_cnt < QCNT_W'(QUEUE_DEPTH)) || pop)
    else $error("push into a full queue");
`endif

endmodule

[tb/tb_particle_cell_histogram_top.sv]
// testbench of the particle cell histogram: directed, cell hammer, config sweep and random items
module tb_particle_cell_histogram_top;
  import pch_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int HAMMER_ADDS = 32;
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [RAD_W-1:0]        RAD_MAX = RAD_W'(1 << 20);
  localparam logic [COUNT_W-1:0]      COUNT_SAT = '1;

  typedef struct {
    op_e                     op;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [RAD_W-1:0]        radius;
    logic                    grid;
    logic [IDX_W-1:0]        rx;
    logic [IDX_W-1:0]        ry;
    logic [IDX_W-1:0]        rz;
  } particle_cmd_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_W-1:0]        cfg_data_i;
  logic [1:0]              operation_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic signed [POS_W-1:0] pos_z_i;
  logic [RAD_W-1:0]        radius_i;
  logic                    grid_select_i;
  logic [IDX_W-1:0]        read_x_i;
  logic [IDX_W-1:0]        read_y_i;
  logic [IDX_W-1:0]        read_z_i;
  logic                    result_valid_o;
  logic [IDX_W-1:0]        fine_x_o;
  logic [IDX_W-1:0]        fine_y_o;
  logic [IDX_W-1:0]        fine_z_o;
  logic [IDX_W-1:0]        coarse_x_o;
  logic [IDX_W-1:0]        coarse_y_o;
  logic [IDX_W-1:0]        coarse_z_o;
  logic                    is_large_o;
  logic [COUNT_W-1:0]      count_large_o;
  logic [COUNT_W-1:0]      count_small_o;

  cfg_t               grid_cfg;
  logic [COUNT_W-1:0] fine_large_cnt[FINE_CELLS];
  logic [COUNT_W-1:0] fine_small_cnt[FINE_CELLS];
  logic [COUNT_W-1:0] coarse_large_cnt[COARSE_CELLS];
  logic [COUNT_W-1:0] coarse_small_cnt[COARSE_CELLS];
  res_t               results_due[$];
  res_t               recent_adds[$];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  bit                 steady = 1'b0;

  particle_cell_histogram_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .radius_i       (radius_i),
    .grid_select_i  (grid_select_i),
    .read_x_i       (read_x_i),
    .read_y_i       (read_y_i),
    .read_z_i       (read_z_i),
    .result_valid_o (result_valid_o),
    .fine_x_o       (fine_x_o),
    .fine_y_o       (fine_y_o),
    .fine_z_o       (fine_z_o),
    .coarse_x_o     (coarse_x_o),
    .coarse_y_o     (coarse_y_o),
    .coarse_z_o     (coarse_z_o),
    .is_large_o     (is_large_o),
    .count_large_o  (count_large_o),
    .count_small_o  (count_small_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_error(string msg);
    if (mismatches < 40) $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_error($sformatf("%s: got %0d expected %0d", name, got, want));
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && result_valid_o) begin
      if (results_due.size() == 0) begin
        report_error("result with no item pending");
      end else begin
        want = results_due.pop_front();
        check_field("fine_x", fine_x_o, want.fx);
        check_field("fine_y", fine_y_o, want.fy);
        check_field("fine_z", fine_z_o, want.fz);
        check_field("coarse_x", coarse_x_o, want.cx);
        check_field("coarse_y", coarse_y_o, want.cy);
        check_field("coarse_z", coarse_z_o, want.cz);
        check_field("is_large", is_large_o, want.is_large);
        check_field("count_large", count_large_o, want.cnt_l);
        check_field("count_small", count_small_o, want.cnt_s);
      end
    end
  end

  function automatic void clear_counts();
    foreach (fine_large_cnt[i]) begin
      fine_large_cnt[i] = '0;
      fine_small_cnt[i] = '0;
    end
    foreach (coarse_large_cnt[i]) begin
      coarse_large_cnt[i] = '0;
      coarse_small_cnt[i] = '0;
    end
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(logic [COUNT_W-1:0] v);
    return (v == COUNT_SAT) ? v : v + 1'b1;
  endfunction

  // floored scaled offset from the origin, clamped to the grid
  function automatic logic [IDX_W-1:0] grid_cell(logic signed [POS_W-1:0] pos,
                                                 logic signed [POS_W-1:0] origin,
                                                 logic [CPM_W-1:0] cpm, int n);
    longint offset;
    longint scaled;
    offset = longint'(pos) - longint'(origin);
    if (offset <= 0) return '0;
    scaled = (offset * longint'(cpm)) >>> SCALE_SHIFT;
    if (scaled > n - 1) return IDX_W'(n - 1);
    return IDX_W'(scaled);
  endfunction

  function automatic res_t histogram_step(particle_cmd_t c);
    res_t r;
    int   fi;
    int   ci;
    int   ri;
    r = '0;
    case (c.op)
      OP_ADD: begin
        r.fx       = grid_cell(c.px, grid_cfg.dmin_x, grid_cfg.fine_cpm, FINE_NX);
        r.fy       = grid_cell(c.py, grid_cfg.dmin_y, grid_cfg.fine_cpm, FINE_NY);
        r.fz       = grid_cell(c.pz, grid_cfg.dmin_z, grid_cfg.fine_cpm, FINE_NZ);
        r.cx       = grid_cell(c.px, grid_cfg.dmin_x, grid_cfg.coarse_cpm, COARSE_NX);
        r.cy       = grid_cell(c.py, grid_cfg.dmin_y, grid_cfg.coarse_cpm, COARSE_NY);
        r.cz       = grid_cell(c.pz, grid_cfg.dmin_z, grid_cfg.coarse_cpm, COARSE_NZ);
        r.is_large = (c.radius > grid_cfg.rad_thr);
        fi = r.fx + FINE_NX * (r.fy + FINE_NY * r.fz);
        ci = r.cx + COARSE_NX * (r.cy + COARSE_NY * r.cz);
        if (r.is_large) begin
          fine_large_cnt[fi]   = sat_inc(fine_large_cnt[fi]);
          coarse_large_cnt[ci] = sat_inc(coarse_large_cnt[ci]);
        end else begin
          fine_small_cnt[fi]   = sat_inc(fine_small_cnt[fi]);
          coarse_small_cnt[ci] = sat_inc(coarse_small_cnt[ci]);
        end
      end
      OP_CLEAR: clear_counts();
      OP_READ: begin
        if (!c.grid) begin
          if (c.rx < FINE_NX && c.ry < FINE_NY && c.rz < FINE_NZ) begin
            ri = c.rx + FINE_NX * (c.ry + FINE_NY * c.rz);
            r.cnt_l = fine_large_cnt[ri];
            r.cnt_s = fine_small_cnt[ri];
          end
        end else begin
          if (c.rx < COARSE_NX && c.ry < COARSE_NY && c.rz < COARSE_NZ) begin
            ri = c.rx + COARSE_NX * (c.ry + COARSE_NY * c.rz);
            r.cnt_l = coarse_large_cnt[ri];
            r.cnt_s = coarse_small_cnt[ri];
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // position spread over the grid span with some margin on both sides
  function automatic logic signed [POS_W-1:0] near_grid(logic signed [POS_W-1:0] origin,
                                                        int n);
    longint span;
    if (grid_cfg.fine_cpm == 0) return POS_W'($urandom);
    span = (longint'(n + 1) << SCALE_SHIFT) / longint'(grid_cfg.fine_cpm);
    if (span > 67108864) span = 67108864;
    return POS_W'(longint'(origin) + longint'($urandom_range(0, span)) - span / 16);
  endfunction

  function automatic particle_cmd_t random_cmd();
    particle_cmd_t c;
    res_t          pick_cell;
    int            pick;
    c.op     = OP_ADD;
    c.px     = POS_W'($urandom);
    c.py     = POS_W'($urandom);
    c.pz     = POS_W'($urandom);
    c.radius = RAD_W'($urandom);
    c.grid   = 1'($urandom);
    c.rx     = IDX_W'($urandom);
    c.ry     = IDX_W'($urandom);
    c.rz     = IDX_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      c.op = OP_CLEAR;
    end else if (pick < 5) begin
      c.op = OP_NONE;
    end else if (pick < 32) begin
      c.op = OP_READ;
      if (recent_adds.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick_cell = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
        {c.rx, c.ry, c.rz} = c.grid ? {pick_cell.cx, pick_cell.cy, pick_cell.cz}
                                    : {pick_cell.fx, pick_cell.fy, pick_cell.fz};
      end
    end else begin
      if ($urandom_range(0, 7) != 0) begin
        c.px = near_grid(grid_cfg.dmin_x, FINE_NX);
        c.py = near_grid(grid_cfg.dmin_y, FINE_NY);
        c.pz = near_grid(grid_cfg.dmin_z, FINE_NZ);
      end
      case ($urandom_range(0, 5))
        0: c.radius = '0;
        1: c.radius = grid_cfg.rad_thr;
        2: c.radius = grid_cfg.rad_thr + 1'b1;
        3: c.radius = RAD_W'($urandom_range(0, RAD_MAX));
        default: ;
      endcase
    end
    return c;
  endfunction

  task automatic idle_gap();
    int n;
    n = 0;
    if (!steady) begin
      n = $urandom_range(0, 99);
      n = (n < 50) ? 0 : (n < 88) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(particle_cmd_t c);
    res_t r;
    @(negedge clk_i);
    start         <= 1'b1;
    operation_i   <= c.op;
    pos_x_i       <= c.px;
    pos_y_i       <= c.py;
    pos_z_i       <= c.pz;
    radius_i      <= c.radius;
    grid_select_i <= c.grid;
    read_x_i      <= c.rx;
    read_y_i      <= c.ry;
    read_z_i      <= c.rz;
    do @(posedge clk_i); while (busy);
    r = histogram_step(c);
    results_due.push_back(r);
    if (c.op == OP_ADD) begin
      recent_adds.push_back(r);
      if (recent_adds.size() > 16) void'(recent_adds.pop_front());
    end
    idle_gap();
  endtask

  task automatic add_at(input logic signed [POS_W-1:0] x, y, z, input logic [RAD_W-1:0] rad);
    particle_cmd_t c;
    c        = random_cmd();
    c.op     = OP_ADD;
    c.px     = x;
    c.py     = y;
    c.pz     = z;
    c.radius = rad;
    send_item(c);
  endtask

  task automatic read_at(input logic g, input logic [IDX_W-1:0] x, y, z);
    particle_cmd_t c;
    c      = random_cmd();
    c.op   = OP_READ;
    c.grid = g;
    c.rx   = x;
    c.ry   = y;
    c.rz   = z;
    send_item(c);
  endtask

  task automatic send_op(op_e op);
    particle_cmd_t c;
    c    = random_cmd();
    c.op = op;
    send_item(c);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
  endtask

  task automatic set_config(cfg_t c);
    write_reg(REG_DMIN_X, CFG_W'(c.dmin_x));
    write_reg(REG_DMIN_Y, CFG_W'(c.dmin_y));
    write_reg(REG_DMIN_Z, CFG_W'(c.dmin_z));
    write_reg(REG_FINE_CPM, CFG_W'(c.fine_cpm));
    write_reg(REG_COARSE_CPM, CFG_W'(c.coarse_cpm));
    write_reg(REG_RAD_THR, CFG_W'(c.rad_thr));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    grid_cfg = c;
  endtask

  task automatic run_phase(cfg_t c, int items);
    wait_drained();
    set_config(c);
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 59) == 0) wait_drained();
      send_item(random_cmd());
    end
    steady = 1'b0;
  endtask

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.dmin_x     = DMIN_X_RST;
    c.dmin_y     = DMIN_Y_RST;
    c.dmin_z     = DMIN_Z_RST;
    c.fine_cpm   = FINE_CPM_RST;
    c.coarse_cpm = COARSE_CPM_RST;
    c.rad_thr    = RAD_THR_RST;
    return c;
  endfunction

  // reset config: origin, range extremes, bad reads, undefined op, clear
  task automatic test_corner_items();
    res_t last;
    add_at(grid_cfg.dmin_x, grid_cfg.dmin_y, grid_cfg.dmin_z, '0);
    add_at(POS_MIN, POS_MIN, POS_MIN, '1);
    add_at(POS_MAX, POS_MAX, POS_MAX, RAD_MAX);
    add_at('0, '0, '0, RAD_W'(1));
    add_at('0, '0, '0, '0);
    last = recent_adds[recent_adds.size() - 1];
    send_op(OP_NONE);
    read_at(1'b0, last.fx, last.fy, last.fz);
    read_at(1'b1, last.cx, last.cy, last.cz);
    read_at(1'b0, IDX_W'(FINE_NX - 1), IDX_W'(FINE_NY - 1), IDX_W'(FINE_NZ - 1));
    read_at(1'b1, IDX_W'(COARSE_NX - 1), IDX_W'(COARSE_NY - 1), IDX_W'(COARSE_NZ - 1));
    read_at(1'b0, '0, '0, '0);
    read_at(1'b0, IDX_W'(FINE_NX), '0, '0);
    read_at(1'b0, '0, IDX_W'(FINE_NY), '0);
    read_at(1'b0, '0, '0, IDX_W'(FINE_NZ));
    read_at(1'b1, IDX_W'(COARSE_NX), '0, '0);
    read_at(1'b1, '0, IDX_W'(COARSE_NY), '0);
    read_at(1'b1, '0, '0, IDX_W'(COARSE_NZ));
    read_at(1'b1, '1, '1, '1);
    send_op(OP_CLEAR);
    read_at(1'b1, last.cx, last.cy, last.cz);
    read_at(1'b0, IDX_W'(FINE_NX - 1), IDX_W'(FINE_NY - 1), IDX_W'(FINE_NZ - 1));
  endtask

  // hammer one cell back to back with alternating large and small items
  task automatic test_cell_hammer();
    res_t last;
    wait_drained();
    send_op(OP_CLEAR);
    steady = 1'b1;
    for (int i = 0; i < 2 * HAMMER_ADDS; i++) add_at('0, '0, '0, RAD_W'(i & 1));
    steady = 1'b0;
    last = recent_adds[recent_adds.size() - 1];
    read_at(1'b0, last.fx, last.fy, last.fz);
    read_at(1'b1, last.cx, last.cy, last.cz);
  endtask

  task automatic test_random_traffic();
    run_phase(default_cfg(), 150);
    run_phase(default_cfg(), 150);
  endtask

  task automatic test_config_sweep();
    cfg_t c;
    c.dmin_x     = POS_MIN;
    c.dmin_y     = POS_MIN;
    c.dmin_z     = POS_MIN;
    c.fine_cpm   = '1;
    c.coarse_cpm = '1;
    c.rad_thr    = RAD_MAX;
    run_phase(c, 100);
    c.dmin_x     = POS_MAX;
    c.dmin_y     = POS_MAX;
    c.dmin_z     = POS_MAX;
    c.fine_cpm   = CPM_W'(1);
    c.coarse_cpm = CPM_W'(1);
    c.rad_thr    = '0;
    run_phase(c, 80);
    // zero scale puts every particle in cell zero
    c.dmin_x     = '0;
    c.dmin_y     = POS_W'($urandom);
    c.dmin_z     = '0;
    c.fine_cpm   = '0;
    c.coarse_cpm = '0;
    c.rad_thr    = '1;
    run_phase(c, 80);
    repeat (2) begin
      c.dmin_x     = POS_W'($urandom);
      c.dmin_y     = POS_W'($urandom);
      c.dmin_z     = POS_W'($urandom);
      c.fine_cpm   = CPM_W'($urandom);
      c.coarse_cpm = CPM_W'($urandom);
      c.rad_thr    = RAD_W'($urandom_range(0, RAD_MAX));
      run_phase(c, 80);
    end
    run_phase(default_cfg(), 40);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_DMIN_X;
    cfg_data_i    = '0;
    operation_i   = OP_ADD;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    radius_i      = '0;
    grid_select_i = 1'b0;
    read_x_i      = '0;
    read_y_i      = '0;
    read_z_i      = '0;
    grid_cfg      = default_cfg();
    clear_counts();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i); while (busy);

    test_corner_items();
    test_cell_hammer();
    test_random_traffic();
    test_config_sweep();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
